// ===== sv/rldm_pkg.sv =====
// Shared types, register indexes and helpers for the radial lens distortion map.
`timescale 1ns / 1ps

package rldm_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 21;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_0       = 3'd0,
    CFG_COEF_1       = 3'd1,
    CFG_COEF_2       = 3'd2,
    CFG_COEF_3       = 3'd3,
    CFG_LENS_SHIFT   = 3'd4,
    CFG_ASPECT_RATIO = 3'd5,
    CFG_ASPECT_RECIP = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [20:0] coef_0;
    logic signed [20:0] coef_1;
    logic signed [20:0] coef_2;
    logic signed [20:0] coef_3;
    logic signed [17:0] lens_shift;
    logic        [19:0] aspect_ratio;
    logic        [19:0] aspect_recip;
  } cfg_t;

  typedef struct packed {
    logic               eye;
    logic signed [18:0] x;
    logic signed [21:0] y;
    logic        [25:0] r2;
  } pt_t;

  function automatic logic signed [18:0] lens_off(input cfg_t cfg, input logic eye);
    logic signed [18:0] sh;
    sh = 19'($signed(cfg.lens_shift));
    return eye ? sh : -sh;
  endfunction

endpackage

// ===== sv/radial_lens_distortion_map_top.sv =====
// Top level of the radial lens distortion map: registers, pipeline and handshake.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_stall_o    eye_i, pixel_x_i, pixel_y_i
//   result   out        out_valid_o / out_stall_i  src_u_o, src_v_o, clipped_o
//   config   in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One transfer per cycle sustained while no result is stalled; each item passes from
// input to result through the 12 register stages (3 front, 2 per Horner step for 3 steps, 3 back).
// Reset clears valid bits and loads the register defaults.
// A stalled result holds the whole pipeline; in_stall_o rises only while a result
// waits and out_stall_i is high, so nothing is lost or repeated.
`timescale 1ns / 1ps

module radial_lens_distortion_map_top
  import rldm_pkg::*;
#(
  parameter int GRID_BITS = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 eye_i,
  input  logic [GRID_BITS-1:0] pixel_x_i,
  input  logic [GRID_BITS-1:0] pixel_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [19:0]   src_u_o,
  output logic signed [19:0]   src_v_o,
  output logic                 clipped_o
);

  cfg_t               cfg_q;
  logic               en;
  logic               fr_valid, h2_valid, h1_valid, h0_valid;
  pt_t                fr_pt, h2_pt, h1_pt, h0_pt;
  logic signed [31:0] acc_k3, h2_acc, h1_acc, h0_acc;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc_k3     = 32'($signed(cfg_q.coef_3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_0       <= 21'sd65536;
      cfg_q.coef_1       <= '0;
      cfg_q.coef_2       <= '0;
      cfg_q.coef_3       <= '0;
      cfg_q.lens_shift   <= '0;
      cfg_q.aspect_ratio <= 20'd65536;
      cfg_q.aspect_recip <= 20'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_0:       cfg_q.coef_0       <= cfg_data_i;
        CFG_COEF_1:       cfg_q.coef_1       <= cfg_data_i;
        CFG_COEF_2:       cfg_q.coef_2       <= cfg_data_i;
        CFG_COEF_3:       cfg_q.coef_3       <= cfg_data_i;
        CFG_LENS_SHIFT:   cfg_q.lens_shift   <= cfg_data_i[17:0];
        CFG_ASPECT_RATIO: cfg_q.aspect_ratio <= cfg_data_i[19:0];
        CFG_ASPECT_RECIP: cfg_q.aspect_recip <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  rldm_front #(
    .GRID_BITS(GRID_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .eye_i     (eye_i),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .valid_o   (fr_valid),
    .pt_o      (fr_pt)
  );

  rldm_horner u_horner_2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .pt_i    (fr_pt),
    .acc_i   (acc_k3),
    .coef_i  (cfg_q.coef_2),
    .valid_o (h2_valid),
    .pt_o    (h2_pt),
    .acc_o   (h2_acc)
  );

  rldm_horner u_horner_1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h2_valid),
    .pt_i    (h2_pt),
    .acc_i   (h2_acc),
    .coef_i  (cfg_q.coef_1),
    .valid_o (h1_valid),
    .pt_o    (h1_pt),
    .acc_o   (h1_acc)
  );

  rldm_horner u_horner_0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h1_valid),
    .pt_i    (h1_pt),
    .acc_i   (h1_acc),
    .coef_i  (cfg_q.coef_0),
    .valid_o (h0_valid),
    .pt_o    (h0_pt),
    .acc_o   (h0_acc)
  );

  rldm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .valid_i   (h0_valid),
    .pt_i      (h0_pt),
    .acc_i     (h0_acc),
    .valid_o   (out_valid_o),
    .src_u_o   (src_u_o),
    .src_v_o   (src_v_o),
    .clipped_o (clipped_o)
  );

endmodule

// ===== sv/rldm_front.sv =====
// Front stages: pixel centre, aspect scaling, lens offset and squared radius.
`timescale 1ns / 1ps

module rldm_front
  import rldm_pkg::*;
#(
  parameter int GRID_BITS = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cfg_t                 cfg_i,
  input  logic                 valid_i,
  input  logic                 eye_i,
  input  logic [GRID_BITS-1:0] pixel_x_i,
  input  logic [GRID_BITS-1:0] pixel_y_i,
  output logic                 valid_o,
  output pt_t                  pt_o
);

  localparam int Scale = 16 - GRID_BITS;
  localparam logic signed [17:0] Size = 18'(1 << GRID_BITS);

  logic signed [17:0] tx_odd, ty_odd, tx, ty;
  logic signed [18:0] x1_d;
  logic signed [38:0] ymul1_d;

  logic               v1_q, v2_q, v3_q;
  logic               eye1_q, eye2_q;
  logic signed [18:0] x1_q, x2_q;
  logic signed [38:0] ymul1_q;
  logic signed [21:0] y2_d, y2_q;
  logic signed [38:0] yr_sum;
  logic signed [37:0] xx2_d, xx2_q;
  logic signed [43:0] yy2_d, yy2_q;
  logic signed [44:0] r2_sum;
  pt_t                pt3_d, pt3_q;

  always_comb begin
    tx_odd  = $signed({{(17-GRID_BITS){1'b0}}, pixel_x_i, 1'b1}) - Size;
    ty_odd  = $signed({{(17-GRID_BITS){1'b0}}, pixel_y_i, 1'b1}) - Size;
    tx      = tx_odd <<< Scale;
    ty      = ty_odd <<< Scale;
    x1_d    = tx + lens_off(cfg_i, eye_i);
    ymul1_d = ty * $signed({1'b0, cfg_i.aspect_recip});
  end

  always_comb begin
    yr_sum = ymul1_q + 39'sd32768;
    y2_d   = yr_sum[37:16];
    xx2_d  = x1_q * x1_q;
    yy2_d  = y2_d * y2_d;
  end

  always_comb begin
    r2_sum    = yy2_q + xx2_q + 45'sd32768;
    pt3_d.eye = eye2_q;
    pt3_d.x   = x2_q;
    pt3_d.y   = y2_q;
    pt3_d.r2  = r2_sum[41:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eye1_q  <= eye_i;
      x1_q    <= x1_d;
      ymul1_q <= ymul1_d;
      eye2_q  <= eye1_q;
      x2_q    <= x1_q;
      y2_q    <= y2_d;
      xx2_q   <= xx2_d;
      yy2_q   <= yy2_d;
      pt3_q   <= pt3_d;
    end
  end

  assign valid_o = v3_q;
  assign pt_o    = pt3_q;

endmodule

// ===== sv/rldm_horner.sv =====
// One Horner step: multiply by r2, then round, add coefficient and saturate.
`timescale 1ns / 1ps

module rldm_horner
  import rldm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pt_t                pt_i,
  input  logic signed [31:0] acc_i,
  input  logic signed [20:0] coef_i,
  output logic               valid_o,
  output pt_t                pt_o,
  output logic signed [31:0] acc_o
);

  logic               va_q, vb_q;
  pt_t                pta_q, ptb_q;
  logic signed [58:0] m_d, m_q;
  logic signed [58:0] m_sum;
  logic signed [42:0] m_rnd;
  logic signed [43:0] s;
  logic signed [31:0] acc_d, acc_q;

  assign m_d = $signed({1'b0, pt_i.r2}) * acc_i;

  always_comb begin
    m_sum = m_q + 59'sd32768;
    m_rnd = m_sum[58:16];
    s     = m_rnd + coef_i;
    if (s > 44'sd2147483647) begin
      acc_d = 32'sh7FFFFFFF;
    end else if (s < -44'sd2147483648) begin
      acc_d = 32'sh80000000;
    end else begin
      acc_d = s[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pta_q <= pt_i;
      m_q   <= m_d;
      ptb_q <= pta_q;
      acc_q <= acc_d;
    end
  end

  assign valid_o = vb_q;
  assign pt_o    = ptb_q;
  assign acc_o   = acc_q;

endmodule

// ===== sv/rldm_back.sv =====
// Back stages: scale by the polynomial, undo offset and aspect, map and saturate.
`timescale 1ns / 1ps

module rldm_back
  import rldm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  pt_t                pt_i,
  input  logic signed [31:0] acc_i,
  output logic               valid_o,
  output logic signed [19:0] src_u_o,
  output logic signed [19:0] src_v_o,
  output logic               clipped_o
);

  logic               v1_q, v2_q, v3_q;
  logic               eye1_q;
  logic signed [50:0] mx_d, mx_q;
  logic signed [53:0] my_d, my_q;

  logic signed [50:0] mx_sum;
  logic signed [53:0] my_sum;
  logic signed [34:0] xr;
  logic signed [37:0] yr;
  logic signed [34:0] x2_d, x2_q;
  logic signed [58:0] mya_d, mya_q;

  logic signed [58:0] ya_sum;
  logic signed [42:0] yv;
  logic signed [35:0] u_sum;
  logic signed [43:0] v_sum;
  logic signed [34:0] u_full;
  logic signed [42:0] v_full;
  logic signed [19:0] u_d, v_d, u_q, v_q;
  logic               clip_u, clip_v, clip_q;

  always_comb begin
    mx_d = pt_i.x * acc_i;
    my_d = pt_i.y * acc_i;
  end

  always_comb begin
    mx_sum = mx_q + 51'sd32768;
    my_sum = my_q + 54'sd32768;
    xr     = mx_sum[50:16];
    yr     = my_sum[53:16];
    x2_d   = xr - lens_off(cfg_i, eye1_q);
    mya_d  = yr * $signed({1'b0, cfg_i.aspect_ratio});
  end

  always_comb begin
    ya_sum = mya_q + 59'sd32768;
    yv     = ya_sum[58:16];
    u_sum  = x2_q + 36'sd65537;
    v_sum  = yv + 44'sd65537;
    u_full = u_sum[35:1];
    v_full = v_sum[43:1];
    clip_u = 1'b0;
    clip_v = 1'b0;
    if (u_full > 35'sd524287) begin
      u_d    = 20'sh7FFFF;
      clip_u = 1'b1;
    end else if (u_full < -35'sd524288) begin
      u_d    = 20'sh80000;
      clip_u = 1'b1;
    end else begin
      u_d = u_full[19:0];
    end
    if (v_full > 43'sd524287) begin
      v_d    = 20'sh7FFFF;
      clip_v = 1'b1;
    end else if (v_full < -43'sd524288) begin
      v_d    = 20'sh80000;
      clip_v = 1'b1;
    end else begin
      v_d = v_full[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eye1_q <= pt_i.eye;
      mx_q   <= mx_d;
      my_q   <= my_d;
      x2_q   <= x2_d;
      mya_q  <= mya_d;
      u_q    <= u_d;
      v_q    <= v_d;
      clip_q <= clip_u | clip_v;
    end
  end

  assign valid_o   = v3_q;
  assign src_u_o   = u_q;
  assign src_v_o   = v_q;
  assign clipped_o = clip_q;

endmodule

// ===== test/radial_lens_distortion_map_top_test.sv =====
// Self-checking testbench for the radial lens distortion map top level.
`timescale 1ns / 1ps

module radial_lens_distortion_map_top_test
  import rldm_pkg::*;
();

  localparam int GRID_BITS = 9;
  localparam int PIPE_DEPTH = 12;
  localparam logic [GRID_BITS-1:0] GRID_MAX = '1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd7;
  localparam longint ONE_Q16 = 65536;
  localparam longint OUT_MIN = -524288;
  localparam longint OUT_MAX = 524287;

  typedef struct {
    logic signed [19:0] u;
    logic signed [19:0] v;
    logic               clip;
  } coord_t;

  class lens_map_predictor;
    logic signed [20:0] coef[4];
    logic signed [17:0] lens_sh;
    logic        [19:0] aspect;
    logic        [19:0] recip;
    coord_t expected_coords[$];
    int mismatch_cnt;
    int coord_cnt;
    int pixel_cnt;

    function new();
      coef[0] = 21'sd65536;
      coef[1] = '0;
      coef[2] = '0;
      coef[3] = '0;
      lens_sh = '0;
      aspect = 20'd65536;
      recip = 20'd65536;
      mismatch_cnt = 0;
      coord_cnt = 0;
      pixel_cnt = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_COEF_0:       coef[0] = data;
        CFG_COEF_1:       coef[1] = data;
        CFG_COEF_2:       coef[2] = data;
        CFG_COEF_3:       coef[3] = data;
        CFG_LENS_SHIFT:   lens_sh = data[17:0];
        CFG_ASPECT_RATIO: aspect = data[19:0];
        CFG_ASPECT_RECIP: recip = data[19:0];
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_pixel(logic eye, logic [GRID_BITS-1:0] px, logic [GRID_BITS-1:0] py);
      longint off;
      longint x;
      longint y;
      longint r2;
      longint acc;
      longint u;
      longint v;
      coord_t c;
      pixel_cnt++;
      off = eye ? longint'(lens_sh) : -longint'(lens_sh);
      x = (2 * longint'(px) + 1 - (longint'(1) << GRID_BITS)) * (longint'(1) << (16 - GRID_BITS));
      y = (2 * longint'(py) + 1 - (longint'(1) << GRID_BITS)) * (longint'(1) << (16 - GRID_BITS));
      y = round_shift(y * longint'(recip), 16);
      x = x + off;
      r2 = round_shift(x * x + y * y, 16);
      acc = longint'(coef[3]);
      for (int k = 2; k >= 0; k--) begin
        acc = sat32(longint'(coef[k]) + round_shift(r2 * acc, 16));
      end
      x = round_shift(x * acc, 16) - off;
      y = round_shift(round_shift(y * acc, 16) * longint'(aspect), 16);
      u = round_shift(x + ONE_Q16, 1);
      v = round_shift(y + ONE_Q16, 1);
      c.clip = 1'b0;
      if (u > OUT_MAX) begin u = OUT_MAX; c.clip = 1'b1; end
      if (u < OUT_MIN) begin u = OUT_MIN; c.clip = 1'b1; end
      if (v > OUT_MAX) begin v = OUT_MAX; c.clip = 1'b1; end
      if (v < OUT_MIN) begin v = OUT_MIN; c.clip = 1'b1; end
      c.u = u[19:0];
      c.v = v[19:0];
      expected_coords.push_back(c);
    endfunction

    function void check_coord(logic signed [19:0] u, logic signed [19:0] v, logic clip);
      coord_t c;
      coord_cnt++;
      if (expected_coords.size() == 0) begin
        mismatch_cnt++;
        $error("result transfer with nothing expected: src_u %0d src_v %0d", u, v);
        return;
      end
      c = expected_coords.pop_front();
      if (u !== c.u) begin
        mismatch_cnt++;
        $error("src_u mismatch: expected %0d, actual %0d", c.u, u);
      end
      if (v !== c.v) begin
        mismatch_cnt++;
        $error("src_v mismatch: expected %0d, actual %0d", c.v, v);
      end
      if (clip !== c.clip) begin
        mismatch_cnt++;
        $error("clipped mismatch: expected %0d, actual %0d", c.clip, clip);
      end
    endfunction

    function int pending();
      return expected_coords.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 eye_i = 1'b0;
  logic [GRID_BITS-1:0] pixel_x_i = '0;
  logic [GRID_BITS-1:0] pixel_y_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [19:0]   src_u_o;
  logic signed [19:0]   src_v_o;
  logic                 clipped_o;

  lens_map_predictor pred = new();
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  int stall_left = 0;
  int setting_cnt = 0;

  radial_lens_distortion_map_top #(
    .GRID_BITS(GRID_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .eye_i      (eye_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .src_u_o    (src_u_o),
    .src_v_o    (src_v_o),
    .clipped_o  (clipped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [GRID_BITS-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return GRID_MAX;
    return GRID_BITS'($urandom_range(0, GRID_MAX));
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(out_idle_en);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) pred.note_pixel(eye_i, pixel_x_i, pixel_y_i);
    if (rst_ni && out_valid_o && !out_stall_i) pred.check_coord(src_u_o, src_v_o, clipped_o);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[CfgDataW-1:0];
    @(posedge clk_i);
    pred.set_reg(idx, data[CfgDataW-1:0]);
  endtask

  task automatic apply_setting(input int k0, input int k1, input int k2, input int k3,
                               input int sh, input int asp, input int rcp);
    write_reg(CFG_COEF_0, k0);
    write_reg(CFG_COEF_1, k1);
    write_reg(CFG_COEF_2, k2);
    write_reg(CFG_COEF_3, k3);
    write_reg(CFG_LENS_SHIFT, sh);
    write_reg(CFG_ASPECT_RATIO, asp);
    write_reg(CFG_ASPECT_RECIP, rcp);
    write_reg(CFG_IDX_SPARE, int'($urandom));
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  task automatic send_pixel(input logic eye, input logic [GRID_BITS-1:0] px,
                            input logic [GRID_BITS-1:0] py);
    eye_i <= eye;
    pixel_x_i <= px;
    pixel_y_i <= py;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pred.pending() != 0);
  endtask

  task automatic send_corners();
    for (int e = 0; e < 2; e++) begin
      send_pixel(e[0], '0, '0);
      send_pixel(e[0], GRID_MAX, GRID_MAX);
      send_pixel(e[0], '0, GRID_MAX);
      send_pixel(e[0], GRID_MAX, '0);
    end
    wait_idle();
  endtask

  task automatic run_pixels(input int count, input bit hold_mid);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = pick_gap(in_idle_en);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if (hold_mid && i == count / 2) wait_idle();
      send_pixel($urandom_range(0, 1), pick_pixel(), pick_pixel());
    end
    wait_idle();
  endtask

  task automatic random_setting();
    int asp;
    if ($urandom_range(0, 2) != 0) begin
      asp = $urandom_range(32768, 131072);
      apply_setting(65536 + int'($urandom_range(0, 16384)) - 8192,
                    int'($urandom_range(0, 65536)) - 32768,
                    int'($urandom_range(0, 65536)) - 32768,
                    int'($urandom_range(0, 65536)) - 32768,
                    int'($urandom_range(0, 26214)) - 13107,
                    asp, int'((64'd1 << 32) / asp));
    end else begin
      apply_setting(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), int'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_corners();
    apply_setting(1048575, 1048575, 1048575, 1048575, 65536, 1048575, 1048575);
    send_corners();
    apply_setting(-1048576, -1048576, -1048576, -1048576, -65536, 0, 0);
    send_corners();

    for (int p = 0; p < 7; p++) begin
      {in_idle_en, out_idle_en} = 2'(p == 0 ? 3 : $urandom_range(0, 3));
      random_setting();
      run_pixels(56, p == 1 || p == 4);
    end

    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (pred.pending() != 0) begin
      pred.mismatch_cnt += pred.pending();
      $error("%0d expected results never arrived", pred.pending());
    end
    $display("Run covered %0d pixel transfers and %0d result transfers under %0d settings,",
             pred.pixel_cnt, pred.coord_cnt, setting_cnt + 1);
    $display("with corner pixels, saturating coefficients and zero aspect registers.");
    if (pred.mismatch_cnt == 0) begin
      $display("PASS radial_lens_distortion_map_top");
    end else begin
      $display("FAIL radial_lens_distortion_map_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL radial_lens_distortion_map_top");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rldm_pkg.sv
sv/rldm_front.sv
sv/rldm_horner.sv
sv/rldm_back.sv
sv/radial_lens_distortion_map_top.sv
test/radial_lens_distortion_map_top_test.sv
